// ===== hw/rtl/vpid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity PID package
// Shared types and fixed constants for the incremental PID controller.
// ----------------------------------------------------------------------------
package vpid_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_NOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_OLDER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 3'd6;

  // Multiplier digit width and the width of the wide operand and term sum.
  localparam int DIGIT_W = 16;
  localparam int SUM_W   = 64;

  // Every shifted product saturates to this many signed bits.
  localparam int TERM_W  = 62;

  // Product sequence: three weighted error terms, then the gain product.
  localparam int TERM_IDX_W = 2;
  localparam logic [TERM_IDX_W-1:0] TERM_NOW   = 2'd0;
  localparam logic [TERM_IDX_W-1:0] TERM_LAST  = 2'd1;
  localparam logic [TERM_IDX_W-1:0] TERM_OLDER = 2'd2;
  localparam logic [TERM_IDX_W-1:0] TERM_GAIN  = 2'd3;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SHIFT,
    ST_DRIVE
  } vpid_state_t;

endpackage

// ===== hw/rtl/vpid_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity PID channel interfaces
// Valid/ready channels for samples, drive results and register writes.
// ----------------------------------------------------------------------------

// Measured sample channel.
interface vpid_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] measured_value;

  modport source (output valid, output measured_value, input ready);
  modport sink   (input valid, input measured_value, output ready);
endinterface

// Drive result channel.
interface vpid_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive_out;
  logic                         at_upper;
  logic                         at_lower;

  modport source (output valid, output drive_out, output at_upper, output at_lower,
                  input ready);
  modport sink   (input valid, input drive_out, input at_upper, input at_lower,
                  output ready);
endinterface

// Register write channel.
interface vpid_cfg_if #(
  parameter int DATA_WIDTH = 32
);
  import vpid_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [DATA_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/velocity_pid_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity PID controller
// Incremental PID update in signed fixed point with clamped drive output.
// ----------------------------------------------------------------------------
// Each sample request gives one drive result. The error against the setpoint
// is formed in the accept cycle; then four products (three weighted errors and
// the gain product) run through one shared 64 x 17 bit multiplier slice, one
// 16-bit digit of the coefficient per cycle, with a shift and saturate step
// after each product. After the accept cycle the input is not ready until the
// drive update is done, so the block takes no new sample before it has
// finished the last one. The result sits in an output register, so the next
// sample may be accepted while it waits; the update stalls in its drive state
// only if the previous result has still not been taken. Error history and
// drive are cleared only by reset; register writes are taken at any time.
module velocity_pid_controller #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  vpid_in_if.sink    in_chan,
  vpid_out_if.source out_chan,
  vpid_cfg_if.sink   cfg_chan
);
  import vpid_pkg::*;

  localparam int ND     = (DATA_WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int BW     = ND * DIGIT_W;
  localparam int PW     = SUM_W + BW;
  localparam int DIG_CW = (ND > 1) ? $clog2(ND) : 1;
  localparam int PART_W = SUM_W + DIGIT_W + 1;

  localparam logic signed [DATA_WIDTH-1:0] ONE  = DATA_WIDTH'(1) << FRAC_BITS;
  localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [TERM_W-1:0]     TMAX = {1'b0, {(TERM_W-1){1'b1}}};
  localparam logic signed [TERM_W-1:0]     TMIN = {1'b1, {(TERM_W-1){1'b0}}};

  // Configuration registers.
  logic signed [DATA_WIDTH-1:0] setpoint_r, gain_r, coef_now_r, coef_last_r;
  logic signed [DATA_WIDTH-1:0] coef_older_r, upper_r, lower_r;

  // Controller state.
  logic signed [DATA_WIDTH-1:0] last_err_r, older_err_r, drive_r;

  // Sequencer and datapath.
  vpid_state_t                  state_r, state_nxt;
  logic [DIG_CW-1:0]            dig_r;
  logic [TERM_IDX_W-1:0]        term_r;
  logic signed [DATA_WIDTH-1:0] cur_err_r;
  logic signed [PW-1:0]         acc_r, acc_nxt;
  logic signed [SUM_W-1:0]      sum_r;
  logic signed [TERM_W-1:0]     inc_r;

  // Output register.
  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] drive_out_r;
  logic                         at_upper_r, at_lower_r;

  // Control strobes.
  logic accept, mul_en, shift_en, drive_en;

  // Combinational datapath signals.
  logic signed [DATA_WIDTH:0]   diff;
  logic signed [DATA_WIDTH-1:0] err_sat;
  logic signed [SUM_W-1:0]      a_op;
  logic signed [DATA_WIDTH-1:0] b_op;
  logic signed [BW-1:0]         b_ext;
  logic [DIGIT_W-1:0]           digit;
  logic                         top_dig;
  logic signed [DIGIT_W:0]      dig_ext;
  logic signed [PART_W-1:0]     part;
  logic signed [PW-1:0]         acc_shift;
  logic [PW-TERM_W:0]           acc_hi;
  logic signed [TERM_W-1:0]     term_sat;
  logic signed [SUM_W-1:0]      drive_sum;
  logic signed [SUM_W-1:0]      upper_ext, lower_ext;

  // Register writes; writes beyond the register list are dropped.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r   <= '0;
      gain_r       <= ONE;
      coef_now_r   <= ONE;
      coef_last_r  <= -ONE;
      coef_older_r <= '0;
      upper_r      <= SMAX;
      lower_r      <= SMIN;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_SETPOINT:    setpoint_r   <= cfg_chan.data;
        REG_GAIN:        gain_r       <= cfg_chan.data;
        REG_COEF_NOW:    coef_now_r   <= cfg_chan.data;
        REG_COEF_LAST:   coef_last_r  <= cfg_chan.data;
        REG_COEF_OLDER:  coef_older_r <= cfg_chan.data;
        REG_UPPER_LIMIT: upper_r      <= cfg_chan.data;
        REG_LOWER_LIMIT: lower_r      <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (dig_r == '0) state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        state_nxt = (term_r == TERM_GAIN) ? ST_DRIVE : ST_MUL;
      end
      ST_DRIVE: begin
        if (!out_valid_r || out_chan.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_chan.ready = 1'b0;
    mul_en        = 1'b0;
    shift_en      = 1'b0;
    drive_en      = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_chan.ready = 1'b1;
      ST_MUL:   mul_en        = 1'b1;
      ST_SHIFT: shift_en      = 1'b1;
      ST_DRIVE: drive_en      = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  assign accept = in_chan.ready && in_chan.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Saturated error of the incoming sample.
  always_comb begin
    diff = (DATA_WIDTH+1)'(setpoint_r) - (DATA_WIDTH+1)'(in_chan.measured_value);
    if (diff[DATA_WIDTH] != diff[DATA_WIDTH-1]) begin
      err_sat = diff[DATA_WIDTH] ? SMIN : SMAX;
    end else begin
      err_sat = diff[DATA_WIDTH-1:0];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (term_r)
      TERM_NOW: begin
        a_op = SUM_W'(cur_err_r);
        b_op = coef_now_r;
      end
      TERM_LAST: begin
        a_op = SUM_W'(last_err_r);
        b_op = coef_last_r;
      end
      TERM_OLDER: begin
        a_op = SUM_W'(older_err_r);
        b_op = coef_older_r;
      end
      default: begin
        a_op = sum_r;
        b_op = gain_r;
      end
    endcase
  end

  // One digit step: the top digit is signed, lower digits are unsigned.
  always_comb begin
    b_ext   = BW'(b_op);
    digit   = b_ext[dig_r*DIGIT_W +: DIGIT_W];
    top_dig = (dig_r == DIG_CW'(ND-1));
    dig_ext = top_dig ? {digit[DIGIT_W-1], digit} : {1'b0, digit};
    part    = a_op * dig_ext;
    acc_nxt = (top_dig ? PW'(0) : (acc_r <<< DIGIT_W)) + PW'(part);
  end

  // Fraction shift and saturation of the finished product.
  always_comb begin
    acc_shift = acc_r >>> FRAC_BITS;
    acc_hi    = acc_shift[PW-1:TERM_W-1];
    if ((&acc_hi) || !(|acc_hi)) begin
      term_sat = acc_shift[TERM_W-1:0];
    end else begin
      term_sat = acc_hi[PW-TERM_W] ? TMIN : TMAX;
    end
  end

  // Drive update ahead of the clamp.
  assign drive_sum = SUM_W'(drive_r) + SUM_W'(inc_r);
  assign upper_ext = SUM_W'(upper_r);
  assign lower_ext = SUM_W'(lower_r);

  // Digit counter and product index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dig_r  <= DIG_CW'(ND-1);
      term_r <= TERM_NOW;
    end else if (accept) begin
      dig_r  <= DIG_CW'(ND-1);
      term_r <= TERM_NOW;
    end else if (mul_en && dig_r != '0) begin
      dig_r <= dig_r - 1'b1;
    end else if (shift_en) begin
      dig_r  <= DIG_CW'(ND-1);
      term_r <= term_r + 1'b1;
    end
  end

  // Multiplier accumulator, term sum and increment.
  always_ff @(posedge clk) begin
    if (accept) cur_err_r <= err_sat;
    if (mul_en) acc_r <= acc_nxt;
    if (shift_en) begin
      if (term_r == TERM_GAIN) begin
        inc_r <= term_sat;
      end else begin
        sum_r <= ((term_r == TERM_NOW) ? SUM_W'(0) : sum_r) + SUM_W'(term_sat);
      end
    end
  end

  // Controller state update at the end of each request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r  <= '0;
      older_err_r <= '0;
      drive_r     <= '0;
    end else if (drive_en) begin
      older_err_r <= last_err_r;
      last_err_r  <= cur_err_r;
      if (drive_sum > upper_ext) begin
        drive_r <= upper_r;
      end else if (drive_sum < lower_ext) begin
        drive_r <= lower_r;
      end else begin
        drive_r <= drive_sum[DATA_WIDTH-1:0];
      end
    end
  end

  // Output register with clamp flags.
  always_ff @(posedge clk) begin
    if (drive_en) begin
      if (drive_sum > upper_ext) begin
        drive_out_r <= upper_r;
        at_upper_r  <= 1'b1;
        at_lower_r  <= 1'b0;
      end else if (drive_sum < lower_ext) begin
        drive_out_r <= lower_r;
        at_upper_r  <= 1'b0;
        at_lower_r  <= 1'b1;
      end else begin
        drive_out_r <= drive_sum[DATA_WIDTH-1:0];
        at_upper_r  <= 1'b0;
        at_lower_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (drive_en) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.drive_out = drive_out_r;
  assign out_chan.at_upper  = at_upper_r;
  assign out_chan.at_lower  = at_lower_r;

endmodule
